### sv/insertion_sorter_core_assert.svh
// insertion_sorter_core_assert.svh: assertion macros for the sorter RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef INSERTION_SORTER_CORE_ASSERT_SVH
`define INSERTION_SORTER_CORE_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define ISS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define ISS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/iss_pkg.sv
// iss_pkg: shared constants and the cell control type for the insertion sorter.
// No dependencies.
`timescale 1ns / 1ps

package iss_pkg;

    localparam int ISS_DEPTH      = 16;
    localparam int ISS_DATA_WIDTH = 32;

    typedef struct packed {
        logic insert;
        logic shift;
    } iss_ctrl_t;

endpackage

### sv/insertion_sorter_core.sv
// insertion_sorter_core: stable ascending sorter built from a chain of cells.
// Depends on iss_pkg, iss_cell and insertion_sorter_core_assert.svh.
//
// Use: send list elements on the input channel (value, last) one per transfer.
// Each element is compared against every cell at once and the chain opens a
// slot for it, so one element enters per clock while collecting.
// Equal keys keep arrival order. Once DEPTH elements are held, further ones
// are dropped and overflow is raised on every result of that list.
// The transfer with last set enters its element, then the block drains: the
// output channel shows the smallest element in the next cycle and one element
// per cycle follows while out_stall is low; final_res marks the last one.
// Draining a list of n held elements takes n output transfers; in_stall stays
// high from the cycle after the last input until the final output transfer.
// When out_stall is high the head cell holds and nothing shifts.
// Reset empties the chain and clears the overflow flag; no sweep is needed.
`timescale 1ns / 1ps

module insertion_sorter_core #(
    parameter int DEPTH      = iss_pkg::ISS_DEPTH,
    parameter int DATA_WIDTH = iss_pkg::ISS_DATA_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [DATA_WIDTH-1:0] value,
    input  logic                         last,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] sorted_value,
    output logic                         final_res,
    output logic                         overflow
);
    import iss_pkg::*;

    logic                         draining_reg;
    logic                         draining_next;
    logic                         dropped_reg;
    logic                         dropped_next;
    logic                         in_xfer;
    logic                         out_xfer;
    iss_ctrl_t                    ctrl;
    logic [DEPTH-1:0]             cell_takes;
    logic [DEPTH-1:0]             cell_valid;
    logic signed [DATA_WIDTH-1:0] cell_value [DEPTH];

    assign in_stall  = draining_reg;
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = draining_reg && cell_valid[0];
    assign out_xfer  = out_valid && !out_stall;

    assign ctrl.insert = in_xfer && !cell_valid[DEPTH-1];
    assign ctrl.shift  = out_xfer;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                         p_takes;
        logic                         p_valid;
        logic signed [DATA_WIDTH-1:0] p_value;
        logic                         n_valid;
        logic signed [DATA_WIDTH-1:0] n_value;

        if (i == 0)
        begin : g_head
            assign p_takes = 1'b0;
            assign p_valid = 1'b0;
            assign p_value = '0;
        end
        else
        begin : g_body
            assign p_takes = cell_takes[i-1];
            assign p_valid = cell_valid[i-1];
            assign p_value = cell_value[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign n_valid = 1'b0;
            assign n_value = '0;
        end
        else
        begin : g_mid
            assign n_valid = cell_valid[i+1];
            assign n_value = cell_value[i+1];
        end

        iss_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .new_value (value),
            .prev_takes(p_takes),
            .prev_valid(p_valid),
            .prev_value(p_value),
            .next_valid(n_valid),
            .next_value(n_value),
            .takes     (cell_takes[i]),
            .valid     (cell_valid[i]),
            .value     (cell_value[i])
        );
    end

    assign sorted_value = cell_value[0];
    assign final_res    = !cell_valid[1];
    assign overflow     = dropped_reg;

    always_comb
    begin
        draining_next = draining_reg;
        dropped_next  = dropped_reg;
        if (in_xfer)
        begin
            if (cell_valid[DEPTH-1])
                dropped_next = 1'b1;
            if (last)
                draining_next = 1'b1;
        end
        if (out_xfer && final_res)
        begin
            draining_next = 1'b0;
            dropped_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draining_reg <= 1'b0;
            dropped_reg  <= 1'b0;
        end
        else
        begin
            draining_reg <= draining_next;
            dropped_reg  <= dropped_next;
        end
    end

    `include "insertion_sorter_core_assert.svh"

    `ISS_ASSERT_ALWAYS(a_valid_packed, $onehot({1'b0, cell_valid} + {{DEPTH{1'b0}}, 1'b1}), "cell valid bits not packed toward head")
    `ISS_ASSERT_ALWAYS(a_head_ordered, !cell_valid[1] || (cell_value[0] <= cell_value[1]), "head cells out of order")
    `ISS_ASSERT_NEXT(a_last_drains, in_xfer && last, out_valid, "no result after last transfer")
    `ISS_ASSERT_ALWAYS(a_no_overlap, !(out_valid && in_xfer), "input taken while draining")

endmodule

### sv/iss_cell.sv
// iss_cell: one storage cell of the sorting chain; compare-and-shift on insert,
// shift toward the head on drain. Depends on iss_pkg.
`timescale 1ns / 1ps

module iss_cell #(
    parameter int DATA_WIDTH = iss_pkg::ISS_DATA_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  iss_pkg::iss_ctrl_t           ctrl,
    input  logic signed [DATA_WIDTH-1:0] new_value,
    input  logic                         prev_takes,
    input  logic                         prev_valid,
    input  logic signed [DATA_WIDTH-1:0] prev_value,
    input  logic                         next_valid,
    input  logic signed [DATA_WIDTH-1:0] next_value,
    output logic                         takes,
    output logic                         valid,
    output logic signed [DATA_WIDTH-1:0] value
);
    import iss_pkg::*;

    logic                         valid_reg;
    logic                         valid_next;
    logic signed [DATA_WIDTH-1:0] value_reg;
    logic signed [DATA_WIDTH-1:0] value_next;

    // strict less-than keeps equal keys in arrival order
    assign takes = !valid_reg || (new_value < value_reg);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.shift)
        begin
            valid_next = next_valid;
            value_next = next_value;
        end
        else if (ctrl.insert && takes)
        begin
            if (prev_takes)
            begin
                valid_next = prev_valid;
                value_next = prev_value;
            end
            else
            begin
                valid_next = 1'b1;
                value_next = new_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;

endmodule

### bench/insertion_sorter_core_tb.sv
// insertion_sorter_core_tb: self-checking bench for the streaming insertion sorter.
// Sends directed and random lists, predicts each sorted drain, checks every result.
// Depends on iss_pkg and insertion_sorter_core.
`timescale 1ns / 1ps

module insertion_sorter_core_tb;
    import iss_pkg::*;

    localparam int DEPTH        = ISS_DEPTH;
    localparam int DW           = ISS_DATA_WIDTH;
    localparam int RANDOM_ITEMS = 350;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef logic signed [DW-1:0] elem_t;

    localparam elem_t ELEM_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam elem_t ELEM_MIN = {1'b1, {(DW-1){1'b0}}};

    typedef struct {
        elem_t sorted_value;
        logic  final_res;
        logic  overflow;
    } sorted_out_t;

    class sort_scoreboard;
        elem_t       held_values[DEPTH];
        int          held_count;
        bit          dropped;
        sorted_out_t pending_sorted[$];
        int          errors;

        function new();
            held_count = 0;
            dropped    = 1'b0;
            errors     = 0;
        endfunction

        // Stable insert: a new element lands after all held elements equal to it.
        function void note_element(elem_t v, logic is_last);
            int          pos;
            int          i;
            sorted_out_t r;
            if (held_count >= DEPTH)
            begin
                dropped = 1'b1;
            end
            else
            begin
                pos = held_count;
                while (pos > 0 && v < held_values[pos-1])
                    pos--;
                for (i = held_count; i > pos; i--)
                    held_values[i] = held_values[i-1];
                held_values[pos] = v;
                held_count++;
            end
            if (is_last)
            begin
                for (i = 0; i < held_count; i++)
                begin
                    r.sorted_value = held_values[i];
                    r.final_res    = (i == held_count - 1);
                    r.overflow     = dropped;
                    pending_sorted.push_back(r);
                end
                held_count = 0;
                dropped    = 1'b0;
            end
        endfunction

        function void check_output(elem_t v, logic fin, logic ovf);
            sorted_out_t e;
            if (pending_sorted.size() == 0)
            begin
                $error("unexpected transfer: sorted_value=%0d final_res=%b overflow=%b",
                       v, fin, ovf);
                errors++;
                return;
            end
            e = pending_sorted.pop_front();
            if (v !== e.sorted_value)
            begin
                $error("sorted_value: expected %0d, got %0d", e.sorted_value, v);
                errors++;
            end
            if (fin !== e.final_res)
            begin
                $error("final_res: expected %b, got %b", e.final_res, fin);
                errors++;
            end
            if (ovf !== e.overflow)
            begin
                $error("overflow: expected %b, got %b", e.overflow, ovf);
                errors++;
            end
        endfunction
    endclass

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    elem_t value;
    logic  last;
    logic  out_valid;
    logic  out_stall;
    elem_t sorted_value;
    logic  final_res;
    logic  overflow;

    sort_scoreboard sb = new();

    int cycle_count;
    int rx_count;
    int burst_left;
    bit gaps_on;
    int items_sent;

    insertion_sorter_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .value        (value),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sorted_value (sorted_value),
        .final_res    (final_res),
        .overflow     (overflow)
    );

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        value       = '0;
        last        = 1'b0;
        out_stall   = 1'b0;
        cycle_count = 0;
        rx_count    = 0;
        burst_left  = 0;
        gaps_on     = 1'b1;
        items_sent  = 0;
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: check each output transfer, then pick next stall from a shifting pattern.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_output(sorted_value, final_res, overflow);
        rx_count++;
        case ((rx_count / 48) % 4)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= (rx_count % 3 == 0);
        endcase
    end

    task automatic send_element(elem_t v, logic is_last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            if (gaps_on)
            begin
                gap = $urandom_range(1, 6);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        value    <= v;
        last     <= is_last;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_element(v, is_last);
        burst_left--;
        items_sent++;
    endtask

    function automatic elem_t pick_value(int mode);
        elem_t v;
        case (mode)
            0: v = elem_t'($urandom);
            1: v = elem_t'($signed($urandom_range(0, 8)) - 4);
            2:
            begin
                case ($urandom_range(0, 5))
                    0: v = ELEM_MIN;
                    1: v = ELEM_MAX;
                    2: v = '0;
                    3: v = '1;
                    4: v = ELEM_MIN + 1;
                    default: v = ELEM_MAX - 1;
                endcase
            end
            default: v = ($urandom_range(0, 1) != 0) ? elem_t'($urandom)
                                                      : elem_t'($urandom_range(0, 15));
        endcase
        return v;
    endfunction

    task automatic send_list(int len, int mode);
        int i;
        for (i = 0; i < len; i++)
            send_element(pick_value(mode), i == len - 1);
    endtask

    initial
    begin
        int i;
        int len;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-element list
        send_element(ELEM_MAX, 1'b1);

        // extremes, sign boundary and duplicate keys
        send_element(ELEM_MIN, 1'b0);
        send_element(ELEM_MAX, 1'b0);
        send_element('0, 1'b0);
        send_element('1, 1'b0);
        send_element(elem_t'(1), 1'b0);
        send_element(elem_t'(5), 1'b0);
        send_element(elem_t'(5), 1'b0);
        send_element('1, 1'b1);

        // full store, then the final element is dropped
        for (i = 0; i <= DEPTH; i++)
            send_element(elem_t'(100 - 7 * i), i == DEPTH);

        // overflow must not carry into the next list
        send_element(ELEM_MIN, 1'b1);

        while (items_sent < RANDOM_ITEMS)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(DEPTH + 1, DEPTH + 8);
            else if ($urandom_range(0, 7) == 0)
                len = DEPTH;
            else
                len = $urandom_range(1, DEPTH);
            send_list(len, $urandom_range(0, 3));
        end

        in_valid <= 1'b0;
        last     <= 1'b0;
        while (sb.pending_sorted.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
